// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the odometry rtl
// files that assert include this header by its bare name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ODO_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication form of the above
`define ODO_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

// ----- rtl/core/dd_odo_pkg.sv -----
// shared constants, widths and tables for the differential drive odometry core
// no dependencies
`default_nettype none

package dd_odo_pkg;

    // cordic configuration
    localparam int CORDIC_STEPS     = 16;
    localparam int CORDIC_TABLE_LEN = 24;
    localparam int CORDIC_ITER      = (CORDIC_STEPS > CORDIC_TABLE_LEN) ?
                                      CORDIC_TABLE_LEN : CORDIC_STEPS;
    localparam int ITER_W           = $clog2(CORDIC_ITER);

    // datapath widths
    localparam int XY_W = 33;
    localparam int Z_W  = 34;

    // fixed constants
    localparam logic signed [XY_W-1:0] CORDIC_X0   = 33'sd652032874;
    localparam logic signed [Z_W-1:0]  HALF_TURN_Q = 34'sd2147483648;
    localparam logic signed [Z_W-1:0]  QUARTER_Q   = 34'sd1073741824;
    localparam logic signed [31:0]     RAD_TO_BAM  = 32'sd683565276;
    localparam logic [15:0]            IWS_RESET   = 16'd9526;

    // arctangent table, 2^32 per turn
    function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] idx);
        logic signed [Z_W-1:0] val;
        unique case (idx)
            5'd0:    val = 34'sd536870912;
            5'd1:    val = 34'sd316933406;
            5'd2:    val = 34'sd167458907;
            5'd3:    val = 34'sd85004756;
            5'd4:    val = 34'sd42667331;
            5'd5:    val = 34'sd21354465;
            5'd6:    val = 34'sd10679838;
            5'd7:    val = 34'sd5340245;
            5'd8:    val = 34'sd2670163;
            5'd9:    val = 34'sd1335087;
            5'd10:   val = 34'sd667544;
            5'd11:   val = 34'sd333772;
            5'd12:   val = 34'sd166886;
            5'd13:   val = 34'sd83443;
            5'd14:   val = 34'sd41721;
            5'd15:   val = 34'sd20860;
            5'd16:   val = 34'sd10430;
            5'd17:   val = 34'sd5215;
            5'd18:   val = 34'sd2607;
            5'd19:   val = 34'sd1303;
            5'd20:   val = 34'sd651;
            5'd21:   val = 34'sd325;
            5'd22:   val = 34'sd162;
            5'd23:   val = 34'sd81;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dd_odo_cordic.sv -----
// iterative rotation-mode cordic: one micro-rotation per cycle on a shared add/shift unit
// depends on dd_odo_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module dd_odo_cordic (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [15:0]        angle,
    output logic                    busy,
    output logic signed [31:0]      cos_q,
    output logic signed [31:0]      sin_q
);
    import dd_odo_pkg::*;

    logic                    busy_reg, busy_next;
    logic [ITER_W-1:0]       iter_reg, iter_next;
    logic signed [XY_W-1:0]  x_reg, x_next;
    logic signed [XY_W-1:0]  y_reg, y_next;
    logic signed [Z_W-1:0]   z_reg, z_next;
    logic                    flip_reg, flip_next;

    logic signed [Z_W-1:0]   z_raw;
    logic signed [Z_W-1:0]   z_fold;
    logic                    fold;
    logic signed [XY_W-1:0]  x_sh;
    logic signed [XY_W-1:0]  y_sh;
    logic signed [Z_W-1:0]   atan_val;
    logic signed [XY_W-1:0]  x_neg;
    logic signed [XY_W-1:0]  y_neg;

    // fold the start angle into [-90, 90] degrees
    always_comb
    begin
        z_raw = {{2{angle[15]}}, angle, 16'h0000};
        fold  = 1'b0;
        z_fold = z_raw;
        priority if (z_raw > QUARTER_Q)
        begin
            z_fold = z_raw - HALF_TURN_Q;
            fold   = 1'b1;
        end
        else if (z_raw < -QUARTER_Q)
        begin
            z_fold = z_raw + HALF_TURN_Q;
            fold   = 1'b1;
        end
    end

    // shared shift and add unit
    always_comb
    begin
        x_sh     = x_reg >>> iter_reg;
        y_sh     = y_reg >>> iter_reg;
        atan_val = atan_lut(5'(iter_reg));
    end

    // sequencer
    always_comb
    begin
        busy_next = busy_reg;
        iter_next = iter_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        flip_next = flip_reg;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            x_next    = CORDIC_X0;
            y_next    = '0;
            z_next    = z_fold;
            flip_next = fold;
        end
        else if (busy_reg)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - atan_val;
            end
            else
            begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + atan_val;
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_W'(CORDIC_ITER - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    // undo the fold on the result
    always_comb
    begin
        x_neg = -x_reg;
        y_neg = -y_reg;
        cos_q = flip_reg ? x_neg[31:0] : x_reg[31:0];
        sin_q = flip_reg ? y_neg[31:0] : y_reg[31:0];
    end

    assign busy = busy_reg;

    // assertions
    `ODO_ASSERT_IMP(a_last_iter_ends, busy_reg && !start && (iter_reg == ITER_W'(CORDIC_ITER - 1)),
        ##1 !busy_reg, "cordic did not finish after its last iteration")
    `ODO_ASSERT_IMP(a_start_sets_busy, start, ##1 (busy_reg && (iter_reg == '0)),
        "cordic start did not load the iteration counter")

endmodule

`default_nettype wire

// ----- rtl/core/diff_drive_odometry_core.sv -----
// differential drive odometry top level: wheel velocities in, integrated pose out
// depends on dd_odo_pkg, dd_odo_cordic and assert_macros.svh
//
// usage:
//   s_axis carries one word per update: left and right wheel velocity (Q4.12) and
//   elapsed time (Q0.16 s). m_axis returns one word per update with the new pose
//   (x, y in Q16.16, heading as binary angle) and the linear and yaw rates.
//   cfg_wr_en/cfg_wr_data write the reciprocal wheel separation (Q4.12, 1/m).
// timing:
//   an accepted word starts a cordic on the old heading (one micro-rotation per
//   cycle) while one shared 32x32 multiplier works through the six products.
//   tvalid rises after the sequencer has waited for the cordic, formed the dx, dy
//   and heading products and updated the pose. s_axis_tready is high only when
//   idle, so one update is in flight; a new word waits until the result is taken.
// reset:
//   pose clears to zero, heading to zero, the separation register to 1/0.430 m.
// stall:
//   a result held by m_axis_tready low stays stable and no new word is taken.
`default_nettype none
`include "assert_macros.svh"

module diff_drive_odometry_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // configuration
    input  wire logic          cfg_wr_en,
    input  wire logic [15:0]   cfg_wr_data,
    // input stream
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // [15:0] left_wheel_velocity, [31:16] right_wheel_velocity, [47:32] elapsed_time
    input  wire logic [47:0]   s_axis_tdata,
    // result stream
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // [31:0] position_x, [63:32] position_y, [79:64] heading,
    // [95:80] linear_velocity, [111:96] angular_velocity
    output logic [111:0]       m_axis_tdata
);
    import dd_odo_pkg::*;

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_M_W   = 4'd1;
    localparam logic [3:0] S_M_VDT = 4'd2;
    localparam logic [3:0] S_M_WDT = 4'd3;
    localparam logic [3:0] S_WAIT  = 4'd4;
    localparam logic [3:0] S_M_DX  = 4'd5;
    localparam logic [3:0] S_M_DY  = 4'd6;
    localparam logic [3:0] S_M_DH  = 4'd7;
    localparam logic [3:0] S_UPD_H = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [15:0]         ivs_reg;
    logic signed [15:0]  left_reg, right_reg;
    logic [15:0]         dt_reg;
    logic signed [15:0]  v_reg, w_reg;
    logic signed [31:0]  vdt_reg, wdt_reg;
    logic signed [63:0]  prod_reg;
    logic signed [31:0]  pos_x_reg, pos_y_reg;
    logic [15:0]         heading_reg;

    logic                in_accept;
    logic                out_accept;
    logic signed [16:0]  wheel_sum;
    logic signed [16:0]  wheel_diff;
    logic signed [31:0]  mul_a, mul_b;
    logic signed [63:0]  mul_p;
    logic signed [51:0]  w_shift;
    logic signed [15:0]  w_sat;
    logic signed [21:0]  d_pos;
    logic signed [31:0]  pos_sel;
    logic signed [31:0]  pos_new;

    logic                cordic_busy;
    logic signed [31:0]  cos_q, sin_q;

    // add a position delta to the old position with saturation
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] base,
                                                    input logic signed [21:0] delta);
        logic signed [32:0] sum;
        logic signed [31:0] res;
        sum = {base[31], base} + {{11{delta[21]}}, delta};
        if (sum[32] != sum[31])
        begin
            res = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else
        begin
            res = sum[31:0];
        end
        return res;
    endfunction

    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_accept = m_axis_tvalid && m_axis_tready;

    // wheel sum and difference
    always_comb
    begin
        wheel_sum  = {s_axis_tdata[15], s_axis_tdata[15:0]} +
                     {s_axis_tdata[31], s_axis_tdata[31:16]};
        wheel_diff = {right_reg[15], right_reg} - {left_reg[15], left_reg};
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_M_W:
            begin
                mul_a = {{15{wheel_diff[16]}}, wheel_diff};
                mul_b = {16'h0000, ivs_reg};
            end
            S_M_VDT:
            begin
                mul_a = {{16{v_reg[15]}}, v_reg};
                mul_b = {16'h0000, dt_reg};
            end
            S_M_WDT:
            begin
                mul_a = {{16{w_reg[15]}}, w_reg};
                mul_b = {16'h0000, dt_reg};
            end
            S_M_DX:
            begin
                mul_a = vdt_reg;
                mul_b = cos_q;
            end
            S_M_DY:
            begin
                mul_a = vdt_reg;
                mul_b = sin_q;
            end
            S_M_DH:
            begin
                mul_a = wdt_reg;
                mul_b = RAD_TO_BAM;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // post-processing of the registered product
    always_comb
    begin
        w_shift = prod_reg[63:12];
        priority if (w_shift > 52'sd32767)
        begin
            w_sat = 16'sh7fff;
        end
        else if (w_shift < -52'sd32768)
        begin
            w_sat = 16'sh8000;
        end
        else
        begin
            w_sat = w_shift[15:0];
        end
        d_pos   = prod_reg[63:42];
        pos_sel = (state_reg == S_M_DY) ? pos_x_reg : pos_y_reg;
        pos_new = sat_add(pos_sel, d_pos);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_accept) state_next = S_M_W;
            S_M_W:   state_next = S_M_VDT;
            S_M_VDT: state_next = S_M_WDT;
            S_M_WDT: state_next = S_WAIT;
            S_WAIT:  if (!cordic_busy) state_next = S_M_DX;
            S_M_DX:  state_next = S_M_DY;
            S_M_DY:  state_next = S_M_DH;
            S_M_DH:  state_next = S_UPD_H;
            S_UPD_H: state_next = S_OUT;
            S_OUT:   if (out_accept) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ivs_reg     <= IWS_RESET;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            heading_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                ivs_reg <= cfg_wr_data;
            end
            if (state_reg == S_M_DY)
            begin
                pos_x_reg <= pos_new;
            end
            if (state_reg == S_M_DH)
            begin
                pos_y_reg <= pos_new;
            end
            if (state_reg == S_UPD_H)
            begin
                heading_reg <= heading_reg + prod_reg[59:44];
            end
        end
    end

    // datapath registers, the yaw product is held while the cordic runs
    always_ff @(posedge clk)
    begin
        if (state_reg != S_WAIT)
        begin
            prod_reg <= mul_p;
        end
        if (in_accept)
        begin
            left_reg  <= s_axis_tdata[15:0];
            right_reg <= s_axis_tdata[31:16];
            dt_reg    <= s_axis_tdata[47:32];
            v_reg     <= wheel_sum[16:1];
        end
        if (state_reg == S_M_VDT)
        begin
            w_reg <= w_sat;
        end
        if (state_reg == S_M_WDT)
        begin
            vdt_reg <= prod_reg[31:0];
        end
        if (state_reg == S_WAIT)
        begin
            wdt_reg <= prod_reg[31:0];
        end
    end

    // sin and cos of the old heading
    dd_odo_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_accept),
        .angle (heading_reg),
        .busy  (cordic_busy),
        .cos_q (cos_q),
        .sin_q (sin_q)
    );

    // stream handshakes and result word
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {w_reg, v_reg, heading_reg, pos_y_reg, pos_x_reg};

    // assertions
    `ODO_ASSERT_IMP(a_no_overlap, s_axis_tready, !m_axis_tvalid,
        "input ready while a result is pending")
    `ODO_ASSERT_IMP(a_cordic_done, state_reg == S_M_DX, !cordic_busy,
        "position product started before cordic finished")
    `ODO_ASSERT_IMP(a_accept_starts_cordic, in_accept, ##1 (cordic_busy && (state_reg == S_M_W)),
        "accepted word did not start the cordic and sequencer")
    `ODO_ASSERT_IMP(a_pose_held, m_axis_tvalid && !m_axis_tready,
        ##1 (pos_x_reg == $past(pos_x_reg) && heading_reg == $past(heading_reg)),
        "pose changed while the result was stalled")

endmodule

`default_nettype wire
